// ===== rtl/lrd_pkg.sv =====
// Shared types, constants and the duty lookup table of the LED ramp dimmer.
package lrd_pkg;

	localparam int unsigned MAX_LEVEL      = 100;
	localparam int unsigned PWM_FULL_SCALE = 4096;

	localparam int unsigned NUM_CH   = 2;
	localparam int unsigned GAIN_NUM = 204;
	localparam int unsigned GAIN_DEN = 100;
	localparam int unsigned PWM_CAP  = 255;

	localparam int unsigned LEVEL_W   = 7;
	localparam int unsigned DUTY_W    = 13;
	localparam int unsigned IN_LVL_W  = 8;
	localparam int unsigned CHAN_W    = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned LUT_DEPTH = 2 ** LEVEL_W;

	typedef logic [LEVEL_W-1:0]        level_t;
	typedef logic [DUTY_W-1:0]         duty_t;
	typedef logic signed [IN_LVL_W-1:0] in_level_t;
	typedef logic [CHAN_W-1:0]         chan_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESTORED_WW = 1'b0,
		REG_RESTORED_CW = 1'b1
	} cfg_reg_t;

	localparam level_t MAX_LEVEL_L = LEVEL_W'(MAX_LEVEL);

	// status of one channel's fade step
	typedef struct packed {
		logic moved;    // level stepped toward target
		logic settled;  // at target while still marked changed
	} fade_stat_t;

	typedef struct packed {
		duty_t  duty_ww;
		duty_t  duty_cw;
		logic   write_ww;
		logic   write_cw;
		logic   save_request;
		level_t saved_ww;
		level_t saved_cw;
		level_t read_level;
	} result_t;

	typedef duty_t duty_lut_t [LUT_DEPTH];

	// level -> duty: pwm = min(cap, level*204/100), duty = pwm*full/255
	function automatic duty_lut_t build_duty_lut();
		duty_lut_t   lut;
		int unsigned pwm;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			pwm = (i * GAIN_NUM) / GAIN_DEN;
			if (pwm > PWM_CAP) begin
				pwm = PWM_CAP;
			end
			lut[i] = DUTY_W'((pwm * PWM_FULL_SCALE) / PWM_CAP);
		end
		return lut;
	endfunction

	localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

// ===== rtl/lrd_if.sv =====
// Handshake channel interfaces: item input, result output, register writes.
interface lrd_in_if;
	import lrd_pkg::*;
	logic      valid;
	logic      ready;
	logic [1:0] op;
	chan_t     channel;
	in_level_t level;
	modport source (output valid, op, channel, level, input ready);
	modport sink   (input valid, op, channel, level, output ready);
endinterface

interface lrd_out_if;
	import lrd_pkg::*;
	logic   valid;
	logic   ready;
	duty_t  duty_ww;
	duty_t  duty_cw;
	logic   write_ww;
	logic   write_cw;
	logic   save_request;
	level_t saved_ww;
	level_t saved_cw;
	level_t read_level;
	modport source (output valid, duty_ww, duty_cw, write_ww, write_cw, save_request,
		saved_ww, saved_cw, read_level, input ready);
	modport sink   (input valid, duty_ww, duty_cw, write_ww, write_cw, save_request,
		saved_ww, saved_cw, read_level, output ready);
endinterface

interface lrd_cfg_if;
	import lrd_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	level_t   data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/two_channel_led_ramp_dimmer_core.sv =====
// Top level of the two-channel LED ramp dimmer: item decode, fade state, result register.
//
// Two-channel (warm = 0, cool = 1) LED fader. Every input beat is one command:
// set a channel's target (clamped to 0..100), tick one fade step, read a
// target, or do nothing; each command returns exactly one result beat. A tick
// steps each channel's current level one unit toward its target, marks it
// changed and reports the new PWM duty (0..3276) of every marked channel, taken
// from a 128-entry constant table. When a marked channel is found at its target,
// all marks clear and the result carries a save request with both targets.
// Timing: one input beat per clock while results drain; each result is captured in
// the output register on acceptance. The output register is the only stage, so input
// ready follows "register empty or being drained this cycle"; a stalled result
// holds input off. Register writes (index 0 warm, 1 cool) load the target
// directly, clamped to 100; a write is held off in any cycle that takes an
// input beat, and writes are meant for idle times.
// Reset leaves both targets, levels and marks at zero.
module two_channel_led_ramp_dimmer_core (
	input  logic clk,
	input  logic arst_n,
	lrd_in_if.sink    item,
	lrd_out_if.source result,
	lrd_cfg_if.sink   cfg
);
	import lrd_pkg::*;

	// fade state
	level_t  tgt_q [NUM_CH];
	level_t  cur_q [NUM_CH];
	logic    [NUM_CH-1:0] mark_q;

	// next-state and step signals
	level_t     tgt_d  [NUM_CH];
	level_t     cur_d  [NUM_CH];
	logic       [NUM_CH-1:0] mark_d;
	level_t     cur_step [NUM_CH];
	fade_stat_t stat     [NUM_CH];
	logic       [NUM_CH-1:0] mark_tick;
	logic       finish;

	result_t res_d;
	result_t res_q;
	logic    out_valid_q;

	logic    in_acc;
	logic    cfg_acc;
	op_t     op;
	level_t  set_level;
	logic    chan_ok;
	logic    chan_sel;
	duty_t   duty_new [NUM_CH];

	assign item.ready = !out_valid_q || result.ready;
	assign in_acc     = item.valid && item.ready;
	// an input beat owns the state update; a register write is held off while one is taken
	assign cfg.ready  = !in_acc;
	assign cfg_acc    = cfg.valid && cfg.ready;
	assign op         = op_t'(item.op);
	assign chan_ok    = (item.channel < CHAN_W'(NUM_CH));
	assign chan_sel   = item.channel[0];

	// clamp the signed request into 0..MAX_LEVEL
	always_comb begin
		if (item.level < 0) begin
			set_level = '0;
		end else if (item.level > $signed({1'b0, MAX_LEVEL_L})) begin
			set_level = MAX_LEVEL_L;
		end else begin
			set_level = item.level[LEVEL_W-1:0];
		end
	end

	for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
		lrd_fade_step u_step (
			.cur      (cur_q[g]),
			.tgt      (tgt_q[g]),
			.mark     (mark_q[g]),
			.cur_next (cur_step[g]),
			.stat     (stat[g])
		);
		assign mark_tick[g] = stat[g].moved || mark_q[g];
		assign duty_new[g]  = mark_tick[g] ? DUTY_LUT[cur_step[g]] : '0;
	end

	assign finish = stat[0].settled || stat[1].settled;

	// command decode: next state and result
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			tgt_d[i] = tgt_q[i];
			cur_d[i] = cur_q[i];
		end
		mark_d = mark_q;
		res_d  = '0;
		unique case (op)
			OP_SET: begin
				if (chan_ok) begin
					tgt_d[chan_sel] = set_level;
				end
			end
			OP_TICK: begin
				for (int i = 0; i < NUM_CH; i++) begin
					cur_d[i] = cur_step[i];
				end
				mark_d         = finish ? '0 : mark_tick;
				res_d.duty_ww  = duty_new[0];
				res_d.duty_cw  = duty_new[1];
				res_d.write_ww = mark_tick[0];
				res_d.write_cw = mark_tick[1];
				if (finish) begin
					res_d.save_request = 1'b1;
					res_d.saved_ww     = tgt_q[0];
					res_d.saved_cw     = tgt_q[1];
				end
			end
			OP_READ: begin
				if (chan_ok) begin
					res_d.read_level = tgt_q[chan_sel];
				end
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				tgt_q[i] <= '0;
				cur_q[i] <= '0;
			end
			mark_q <= '0;
		end else if (in_acc) begin
			for (int i = 0; i < NUM_CH; i++) begin
				tgt_q[i] <= tgt_d[i];
				cur_q[i] <= cur_d[i];
			end
			mark_q <= mark_d;
		end else if (cfg_acc) begin
			// register write loads the target, clamped
			unique case (cfg_reg_t'(cfg.index))
				REG_RESTORED_WW: tgt_q[0] <= (cfg.data > MAX_LEVEL_L) ? MAX_LEVEL_L : cfg.data;
				REG_RESTORED_CW: tgt_q[1] <= (cfg.data > MAX_LEVEL_L) ? MAX_LEVEL_L : cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item.ready) begin
			out_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.duty_ww      = res_q.duty_ww;
	assign result.duty_cw      = res_q.duty_cw;
	assign result.write_ww     = res_q.write_ww;
	assign result.write_cw     = res_q.write_cw;
	assign result.save_request = res_q.save_request;
	assign result.saved_ww     = res_q.saved_ww;
	assign result.saved_cw     = res_q.saved_cw;
	assign result.read_level   = res_q.read_level;

`ifndef SYNTH
	// a finished fade clears every change mark
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op == OP_TICK && finish |=> mark_q == '0)
		else $error("change marks survive a finished fade");

	// a save request only comes from a channel that was rewritten
	a_save_has_write: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.save_request |-> (result.write_ww || result.write_cw))
		else $error("save request without a duty write");

	// levels never leave the legal range
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q[0] <= MAX_LEVEL_L && cur_q[1] <= MAX_LEVEL_L
		&& tgt_q[0] <= MAX_LEVEL_L && tgt_q[1] <= MAX_LEVEL_L)
		else $error("level above maximum");
`endif

endmodule

// ===== rtl/lrd_fade_step.sv =====
// One channel's fade step: move current level one unit toward the target.
module lrd_fade_step (
	input  lrd_pkg::level_t     cur,
	input  lrd_pkg::level_t     tgt,
	input  logic                mark,
	output lrd_pkg::level_t     cur_next,
	output lrd_pkg::fade_stat_t stat
);
	import lrd_pkg::*;

	always_comb begin
		cur_next     = cur;
		stat.moved   = 1'b0;
		stat.settled = 1'b0;
		if (cur > tgt) begin
			cur_next   = cur - level_t'(1);
			stat.moved = 1'b1;
		end else if (cur < tgt) begin
			cur_next   = cur + level_t'(1);
			stat.moved = 1'b1;
		end else begin
			stat.settled = mark;
		end
	end

endmodule
